>>> design/priority_task_scheduler_top_assert.svh
// Assertion macros used by the checker file, pts_checker.sv.
`ifndef PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH

// Property that must hold in every cycle outside reset.
`define PTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/pts_pkg.sv
`default_nettype none

package pts_pkg;

	localparam int MAX_TASKS = 15;
	localparam int SLOT_W    = $clog2(MAX_TASKS + 1);
	localparam int TASK_W    = 4;
	localparam int KIND_W    = 3;
	localparam int DATA_W    = 8;
	localparam int TICK_W    = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_CREATE   = 3'd0,
		KIND_WAIT     = 3'd1,
		KIND_SET_FLAG = 3'd2,
		KIND_WAKE     = 3'd3,
		KIND_SCHEDULE = 3'd4
	} kind_t;

	// Transaction token walking the slot chain.
	typedef struct packed {
		logic              valid;
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] value;
		logic [SLOT_W-1:0] target;    // zero when out of range
		logic              ticking;
		logic [SLOT_W-1:0] cur;
		logic              hit;       // create: slot claimed; schedule: best found
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] best_prio;
		logic [DATA_W-1:0] best_cnt;
		logic [DATA_W-1:0] cur_cnt;
	} tok_t;

endpackage

`default_nettype wire

>>> design/pts_cell.sv
`default_nettype none

module pts_cell (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        en,
	input  wire  [pts_pkg::SLOT_W-1:0] index,
	input  wire  pts_pkg::tok_t        tok_i,
	output pts_pkg::tok_t              tok_o
);

	logic                        present_q;
	logic [pts_pkg::DATA_W-1:0]  prio_q;
	logic [pts_pkg::DATA_W-1:0]  thr_q;
	logic [pts_pkg::DATA_W-1:0]  cnt_q;
	logic                        flag_q;
	pts_pkg::tok_t               tok_q;

	logic                        present_d;
	logic [pts_pkg::DATA_W-1:0]  prio_d;
	logic [pts_pkg::DATA_W-1:0]  thr_d;
	logic [pts_pkg::DATA_W-1:0]  cnt_d;
	logic                        flag_d;
	pts_pkg::tok_t               tok_d;
	logic [pts_pkg::DATA_W-1:0]  cnt_sched;
	logic [pts_pkg::DATA_W-1:0]  diff;
	logic                        awake;
	logic                        mine;
	logic                        take;

	always_comb begin
		present_d = present_q;
		prio_d    = prio_q;
		thr_d     = thr_q;
		cnt_d     = cnt_q;
		flag_d    = flag_q;
		tok_d     = tok_i;
		mine      = (index == tok_i.cur);
		cnt_sched = (tok_i.ticking && flag_q) ? cnt_q + 8'd1 : cnt_q;
		diff      = thr_q - cnt_sched;
		awake     = (diff == 8'd0) || diff[pts_pkg::DATA_W-1];
		take      = 1'b0;
		if (tok_i.valid) begin
			unique case (pts_pkg::kind_t'(tok_i.kind))
				pts_pkg::KIND_CREATE: begin
					if (!tok_i.hit && !present_q) begin
						present_d = 1'b1;
						prio_d    = tok_i.value;
						thr_d     = '0;
						cnt_d     = '0;
						flag_d    = 1'b0;
						tok_d.hit  = 1'b1;
						tok_d.slot = index;
					end
				end
				pts_pkg::KIND_WAIT: begin
					if (mine) thr_d = tok_i.value;
				end
				pts_pkg::KIND_SET_FLAG: begin
					if (mine) flag_d = tok_i.value[0];
				end
				pts_pkg::KIND_WAKE: begin
					if (present_q && index == tok_i.target) cnt_d = cnt_q + 8'd1;
				end
				pts_pkg::KIND_SCHEDULE: begin
					if (present_q) begin
						cnt_d = cnt_sched;
						// ties go to the current task, otherwise keep the earlier slot
						take = awake && (!tok_i.hit || prio_q > tok_i.best_prio ||
							(prio_q == tok_i.best_prio && mine));
						if (take) begin
							tok_d.hit       = 1'b1;
							tok_d.slot      = index;
							tok_d.best_prio = prio_q;
							tok_d.best_cnt  = cnt_sched;
						end
					end
				end
				default: ;
			endcase
			if (mine) tok_d.cur_cnt = cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			tok_q     <= '0;
		end else if (en) begin
			present_q <= present_d;
			tok_q     <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prio_q <= prio_d;
			thr_q  <= thr_d;
			cnt_q  <= cnt_d;
			flag_q <= flag_d;
		end
	end

	assign tok_o = tok_q;

endmodule

`default_nettype wire

>>> design/priority_task_scheduler_top.sv
// channel  | handshake           | payload
// item     | item_valid/stall    | kind, value, target_task, tick_count
// result   | result_valid/stall  | chosen_task, failed, wake_count, running_task
//
// One transaction at a time: it enters a launch register, passes one slot cell
// per cycle while the chain is not held, then lands in the result register; the
// next item is accepted only once it has landed there.
// Reset empties every slot and clears the running task and the last tick.
// A stalled result freezes the chain once the next result reaches its end.
`default_nettype none

module priority_task_scheduler_top (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         item_valid,
	output logic                        item_stall,
	input  wire  [pts_pkg::KIND_W-1:0]  kind,
	input  wire  [pts_pkg::DATA_W-1:0]  value,
	input  wire  [pts_pkg::TASK_W-1:0]  target_task,
	input  wire  [pts_pkg::TICK_W-1:0]  tick_count,
	output logic                        result_valid,
	input  wire                         result_stall,
	output logic [pts_pkg::TASK_W-1:0]  chosen_task,
	output logic                        failed,
	output logic [pts_pkg::DATA_W-1:0]  wake_count,
	output logic [pts_pkg::TASK_W-1:0]  running_task
);

	logic                        busy_q;
	logic                        out_valid_q;
	logic [pts_pkg::SLOT_W-1:0]  current_q;
	logic [pts_pkg::TICK_W-1:0]  last_tick_q;
	logic [pts_pkg::TASK_W-1:0]  chosen_q;
	logic                        failed_q;
	logic [pts_pkg::DATA_W-1:0]  wake_count_q;
	pts_pkg::tok_t               launch_q;
	pts_pkg::tok_t               launch_d;
	pts_pkg::tok_t               chain [0:pts_pkg::MAX_TASKS];
	pts_pkg::tok_t               tail;

	logic                        accept;
	logic                        en;
	logic                        load;
	logic                        is_sched;
	logic                        switch_task;
	logic [pts_pkg::TASK_W-1:0]  chosen_d;
	logic [pts_pkg::SLOT_W-1:0]  cur_d;
	logic [pts_pkg::DATA_W-1:0]  wc_d;

	assign item_stall = busy_q;
	assign accept     = item_valid && !busy_q;
	assign tail       = chain[pts_pkg::MAX_TASKS];
	// hold the chain while a finished transaction cannot enter the result register
	assign en         = !(tail.valid && out_valid_q && result_stall);
	assign load       = tail.valid && en;
	assign is_sched   = (pts_pkg::kind_t'(kind) == pts_pkg::KIND_SCHEDULE);

	always_comb begin
		launch_d           = '0;
		launch_d.valid     = 1'b1;
		launch_d.kind      = kind;
		launch_d.value     = value;
		launch_d.target    = (int'(target_task) <= pts_pkg::MAX_TASKS) ?
			pts_pkg::SLOT_W'(target_task) : '0;
		launch_d.ticking   = is_sched && (tick_count != last_tick_q);
		launch_d.cur       = current_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q    <= '0;
			busy_q      <= 1'b0;
			last_tick_q <= '0;
		end else begin
			if (accept) begin
				launch_q <= launch_d;
				busy_q   <= 1'b1;
				if (is_sched) last_tick_q <= tick_count;
			end else begin
				if (en) launch_q.valid <= 1'b0;
				if (load) busy_q <= 1'b0;
			end
		end
	end

	assign chain[0] = launch_q;

	for (genvar g = 0; g < pts_pkg::MAX_TASKS; g++) begin : g_cell
		pts_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.index  (pts_pkg::SLOT_W'(g + 1)),
			.tok_i  (chain[g]),
			.tok_o  (chain[g+1])
		);
	end

	always_comb begin
		switch_task = (pts_pkg::kind_t'(tail.kind) == pts_pkg::KIND_SCHEDULE) &&
			tail.hit && (tail.slot != tail.cur);
		chosen_d    = '0;
		if (pts_pkg::kind_t'(tail.kind) == pts_pkg::KIND_CREATE && tail.hit)
			chosen_d = pts_pkg::TASK_W'(tail.slot);
		else if (switch_task)
			chosen_d = pts_pkg::TASK_W'(tail.slot);
		cur_d = switch_task ? tail.slot : tail.cur;
		if (switch_task)
			wc_d = tail.best_cnt;
		else if (tail.cur == '0)
			wc_d = '0;
		else
			wc_d = tail.cur_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			current_q   <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			current_q   <= cur_d;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chosen_q     <= chosen_d;
			failed_q     <= (pts_pkg::kind_t'(tail.kind) == pts_pkg::KIND_CREATE) && !tail.hit;
			wake_count_q <= wc_d;
		end
	end

	assign result_valid = out_valid_q;
	assign chosen_task  = chosen_q;
	assign failed       = failed_q;
	assign wake_count   = wake_count_q;
	assign running_task = pts_pkg::TASK_W'(current_q);

endmodule

`default_nettype wire

>>> design/pts_checker.sv
`default_nettype none
`include "priority_task_scheduler_top_assert.svh"

module pts_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         item_valid,
	input wire                         item_stall,
	input wire  [pts_pkg::KIND_W-1:0]  kind,
	input wire  [pts_pkg::DATA_W-1:0]  value,
	input wire  [pts_pkg::TASK_W-1:0]  target_task,
	input wire  [pts_pkg::TICK_W-1:0]  tick_count,
	input wire                         result_valid,
	input wire                         result_stall,
	input wire  [pts_pkg::TASK_W-1:0]  chosen_task,
	input wire                         failed,
	input wire  [pts_pkg::DATA_W-1:0]  wake_count,
	input wire  [pts_pkg::TASK_W-1:0]  running_task
);

	// a new transaction is refused until the current one has finished
	`PTS_ASSERT_NEXT(a_one_in_flight, item_valid && !item_stall, item_stall, "second transaction taken while busy")

	`PTS_ASSERT(a_fail_no_slot, !(result_valid && failed && chosen_task != 4'd0), "failed create reports a slot")

	`PTS_ASSERT(a_idle_count, !(result_valid && running_task == 4'd0 && wake_count != 8'd0), "wake count without a running task")

	`PTS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(chosen_task) && $stable(running_task) && $stable(wake_count), "stalled result changed")

endmodule

bind priority_task_scheduler_top pts_checker u_pts_checker (.*);

`default_nettype wire

>>> tb/priority_task_scheduler_top_test.sv
module priority_task_scheduler_top_test;
	import pts_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;
	localparam int RAND_ITEMS   = 600;
	localparam int WRAP_AT      = 240;
	localparam int WRAP_LEN     = 260;
	localparam int HOLD_AT      = 120;
	localparam int DRAIN_AT     = 200;
	localparam int CALM_TAIL    = 60;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 40;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] value;
		logic [TASK_W-1:0] target;
		logic [TICK_W-1:0] tick;
	} sched_req_t;

	typedef struct packed {
		logic [TASK_W-1:0] chosen;
		logic              failed;
		logic [DATA_W-1:0] wake_cnt;
		logic [TASK_W-1:0] running;
	} sched_resp_t;

	typedef struct packed {
		sched_req_t  req;
		logic        typed;
		sched_resp_t resp;
	} directed_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [DATA_W-1:0] value = '0;
	logic [TASK_W-1:0] target_task = '0;
	logic [TICK_W-1:0] tick_count = '0;
	logic              result_valid;
	logic              result_stall;
	logic [TASK_W-1:0] chosen_task;
	logic              failed;
	logic [DATA_W-1:0] wake_count;
	logic [TASK_W-1:0] running_task;

	logic burst_stall = 1'b0;
	logic hold_stall = 1'b0;
	assign result_stall = burst_stall | hold_stall;

	priority_task_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.value(value),
		.target_task(target_task),
		.tick_count(tick_count),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.chosen_task(chosen_task),
		.failed(failed),
		.wake_count(wake_count),
		.running_task(running_task)
	);

	// Shadow copy of the task table
	logic              tcb_live     [0:MAX_TASKS];
	logic [DATA_W-1:0] tcb_prio     [0:MAX_TASKS];
	logic [DATA_W-1:0] tcb_thresh   [0:MAX_TASKS];
	logic [DATA_W-1:0] tcb_wakes    [0:MAX_TASKS];
	logic              tcb_tickwake [0:MAX_TASKS];
	int                pred_running = 0;
	logic [TICK_W-1:0] pred_tick = '0;

	sched_resp_t   sched_results_due [$];
	directed_row_t directed_rows [$];
	sched_resp_t   got_rs;
	sched_resp_t   due_rs;

	bit long_hold_req = 1'b0;
	bit no_idle = 1'b0;
	int mismatches = 0;
	int results_checked = 0;
	int items_sent = 0;
	int switch_cnt = 0;
	int full_cnt = 0;
	int cycle_cnt = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit running_ok();
		return pred_running >= 1 && pred_running <= MAX_TASKS && tcb_live[pred_running];
	endfunction

	function automatic sched_resp_t predict_sched_outcome(input sched_req_t rq);
		sched_resp_t rs;
		logic [DATA_W-1:0] gap;
		logic ticking;
		logic placed;
		int best;
		int best_prio;
		rs = '0;
		case (rq.kind)
		KIND_CREATE: begin
			rs.failed = 1'b1;
			placed = 1'b0;
			for (int i = 1; i <= MAX_TASKS; i++) begin
				if (!placed && !tcb_live[i]) begin
					tcb_live[i] = 1'b1;
					tcb_prio[i] = rq.value;
					tcb_thresh[i] = '0;
					tcb_wakes[i] = '0;
					tcb_tickwake[i] = 1'b0;
					rs.chosen = TASK_W'(i);
					rs.failed = 1'b0;
					placed = 1'b1;
				end
			end
			if (!placed)
				full_cnt++;
		end
		KIND_WAIT: begin
			if (running_ok())
				tcb_thresh[pred_running] = rq.value;
		end
		KIND_SET_FLAG: begin
			if (running_ok())
				tcb_tickwake[pred_running] = rq.value[0];
		end
		KIND_WAKE: begin
			if (rq.target >= 1 && rq.target <= MAX_TASKS && tcb_live[rq.target])
				tcb_wakes[rq.target] = tcb_wakes[rq.target] + 8'd1;
		end
		KIND_SCHEDULE: begin
			ticking = (rq.tick != pred_tick);
			pred_tick = rq.tick;
			best = 0;
			best_prio = -1;
			for (int i = 1; i <= MAX_TASKS; i++) begin
				if (tcb_live[i]) begin
					if (ticking && tcb_tickwake[i])
						tcb_wakes[i] = tcb_wakes[i] + 8'd1;
					gap = tcb_thresh[i] - tcb_wakes[i];
					// a later slot only takes a tie when it is the running task
					if ((int'(tcb_prio[i]) > best_prio ||
							(int'(tcb_prio[i]) == best_prio && i == pred_running)) &&
							(gap == '0 || gap[DATA_W-1])) begin
						best = i;
						best_prio = int'(tcb_prio[i]);
					end
				end
			end
			if (best != 0 && best != pred_running) begin
				pred_running = best;
				rs.chosen = TASK_W'(best);
				switch_cnt++;
			end
		end
		default: ;
		endcase
		rs.wake_cnt = running_ok() ? tcb_wakes[pred_running] : '0;
		rs.running = TASK_W'(pred_running);
		return rs;
	endfunction

	task automatic add_row(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] v,
			input logic [TASK_W-1:0] t, input logic [TICK_W-1:0] tk, input logic typed,
			input logic [TASK_W-1:0] ch, input logic fl, input logic [DATA_W-1:0] wc,
			input logic [TASK_W-1:0] run);
		directed_row_t row;
		row.req = {k, v, t, tk};
		row.typed = typed;
		row.resp = {ch, fl, wc, run};
		directed_rows.push_back(row);
	endtask

	// Offer one transaction, hold it until taken, then log its outcome.
	task automatic send_item(input sched_req_t rq, input logic use_typed,
			input sched_resp_t typed_rs);
		sched_resp_t prd;
		item_valid <= 1'b1;
		kind <= rq.kind;
		value <= rq.value;
		target_task <= rq.target;
		tick_count <= rq.tick;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		prd = predict_sched_outcome(rq);
		sched_results_due.push_back(use_typed ? typed_rs : prd);
		items_sent++;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	task automatic drain_results();
		@(posedge clk);
		while (sched_results_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin : rx_idle
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!no_idle && $urandom_range(0, 5) == 0) begin
				burst_stall <= 1'b1;
				repeat ($urandom_range(1, 17))
					@(posedge clk);
				burst_stall <= 1'b0;
				repeat ($urandom_range(0, 60))
					@(posedge clk);
			end
		end
	end

	// Long back-pressure: let the block fill up and stall its input.
	initial begin : rx_hold
		wait (long_hold_req);
		@(posedge clk);
		hold_stall <= 1'b1;
		repeat (LONG_HOLD)
			@(posedge clk);
		hold_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			got_rs = {chosen_task, failed, wake_count, running_task};
			results_checked++;
			if (sched_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: chosen %0d failed %0d wake_count %0d running %0d",
						got_rs.chosen, got_rs.failed, got_rs.wake_cnt, got_rs.running);
			end else begin
				due_rs = sched_results_due.pop_front();
				if (got_rs.chosen !== due_rs.chosen || got_rs.failed !== due_rs.failed ||
						got_rs.wake_cnt !== due_rs.wake_cnt || got_rs.running !== due_rs.running) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at result %0d (exp/got): chosen %0d/%0d failed %0d/%0d wake_count %0d/%0d running %0d/%0d",
							results_checked, due_rs.chosen, got_rs.chosen, due_rs.failed,
							got_rs.failed, due_rs.wake_cnt, got_rs.wake_cnt, due_rs.running,
							got_rs.running);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				sched_results_due.size());
			$display("priority_task_scheduler_top test failed");
			$finish;
		end
	end

	initial begin : stimulus
		sched_req_t rq;
		int n_rand;
		int wrap_slot;
		for (int i = 0; i <= MAX_TASKS; i++) begin
			tcb_live[i] = 1'b0;
			tcb_prio[i] = '0;
			tcb_thresh[i] = '0;
			tcb_wakes[i] = '0;
			tcb_tickwake[i] = 1'b0;
		end
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		// kind, value, target, tick, typed, chosen, failed, wake_count, running
		add_row(KIND_SCHEDULE, 8'h00, 4'd0, 32'h0, 1'b1, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_WAIT, 8'h80, 4'd0, 32'h0, 1'b1, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_SET_FLAG, 8'h01, 4'd0, 32'h0, 1'b1, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_WAKE, 8'h00, 4'd0, 32'h0, 1'b1, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_WAKE, 8'h00, 4'd15, 32'h0, 1'b1, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_UNUSED_FIRST, 8'hff, 4'd15, 32'hffffffff, 1'b1, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_UNUSED_LAST, 8'h00, 4'd0, 32'h0, 1'b1, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_CREATE, 8'h00, 4'd0, 32'h0, 1'b1, 4'd1, 1'b0, 8'd0, 4'd0);
		add_row(KIND_CREATE, 8'hff, 4'd0, 32'h0, 1'b1, 4'd2, 1'b0, 8'd0, 4'd0);
		add_row(KIND_CREATE, 8'hff, 4'd0, 32'h0, 1'b1, 4'd3, 1'b0, 8'd0, 4'd0);
		// equal priorities: the earliest slot wins
		add_row(KIND_SCHEDULE, 8'h00, 4'd0, 32'hffffffff, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		// threshold 0x80 counts as a negative difference, so still awake
		add_row(KIND_WAIT, 8'h80, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_SCHEDULE, 8'h00, 4'd0, 32'hffffffff, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_WAIT, 8'h01, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_SCHEDULE, 8'h00, 4'd0, 32'hffffffff, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		// wake the sleeper; the later running task keeps the tie
		add_row(KIND_WAKE, 8'h00, 4'd2, 32'h0, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_SCHEDULE, 8'h00, 4'd0, 32'hffffffff, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_SET_FLAG, 8'hff, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_WAIT, 8'h02, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_SCHEDULE, 8'h00, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_WAIT, 8'h05, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_SCHEDULE, 8'h00, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		// every task asleep: no switch
		add_row(KIND_WAIT, 8'h01, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_SCHEDULE, 8'h00, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		add_row(KIND_SET_FLAG, 8'h00, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);
		// tick change wakes the flagged task
		add_row(KIND_SCHEDULE, 8'h00, 4'd0, 32'h80000000, 1'b0, 4'd0, 1'b0, 8'd0, 4'd0);

		foreach (directed_rows[i])
			send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].resp);
		item_valid <= 1'b0;
		drain_results();

		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			if (n_rand == HOLD_AT)
				long_hold_req = 1'b1;
			if (n_rand == DRAIN_AT) begin
				item_valid <= 1'b0;
				drain_results();
			end
			if (n_rand >= RAND_ITEMS - CALM_TAIL)
				no_idle = 1'b1;
			rq = '0;
			if (n_rand == WRAP_AT) begin
				// hammer one slot until its wake count wraps
				wrap_slot = (pred_running != 0) ? pred_running : 1;
				for (int k = 0; k < WRAP_LEN; k++) begin
					rq.kind = KIND_WAKE;
					rq.value = 8'($urandom);
					rq.target = TASK_W'(wrap_slot);
					rq.tick = $urandom;
					send_item(rq, 1'b0, '0);
				end
				n_rand += WRAP_LEN;
			end else begin
				rq.value = 8'($urandom);
				rq.target = 4'($urandom);
				rq.tick = $urandom;
				case ($urandom_range(0, 99)) inside
				[0:7]: begin
					rq.kind = KIND_CREATE;
					if ($urandom_range(0, 1) == 0)
						rq.value = 8'($urandom_range(0, 3));
				end
				[8:27]: begin
					rq.kind = KIND_WAIT;
					if (running_ok() && $urandom_range(0, 3) != 0)
						rq.value = tcb_wakes[pred_running] + 8'($urandom_range(0, 6)) - 8'd3;
				end
				[28:37]: rq.kind = KIND_SET_FLAG;
				[38:61]: begin
					rq.kind = KIND_WAKE;
					if (pred_running != 0 && $urandom_range(0, 2) == 0)
						rq.target = TASK_W'(pred_running);
				end
				[62:96]: begin
					rq.kind = KIND_SCHEDULE;
					case ($urandom_range(0, 2))
					0: rq.tick = pred_tick;
					1: rq.tick = pred_tick + 32'd1;
					default: ;
					endcase
				end
				default: rq.kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
				endcase
				send_item(rq, 1'b0, '0);
				n_rand++;
			end
		end
		item_valid <= 1'b0;
		while (sched_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);

		$display("%0d transactions sent, %0d results checked, %0d mismatches",
			items_sent, results_checked, mismatches);
		$display("%0d task switches predicted, %0d creates refused on a full table",
			switch_cnt, full_cnt);
		if (mismatches == 0)
			$display("priority_task_scheduler_top test passed");
		else
			$display("priority_task_scheduler_top test failed");
		$finish;
	end

endmodule
